/* rtl/core/msl_pkg.sv */
// Shared constants, codes and types of the multichannel servo slew limiter.
// No dependencies; imported by msl_cfg, multichannel_servo_slew_limiter and the testbench.
package msl_pkg;

    localparam int CHANNELS      = 6;
    localparam int TICK_RATE_HZ  = 50;
    localparam int FRACTION_BITS = 8;

    // Field widths
    localparam int OP_W      = 2;
    localparam int CH_W      = 4;
    localparam int REQ_W     = 17;
    localparam int KIND_W    = 2;
    localparam int OUT_W     = 13;
    localparam int PULSE_W   = 12;
    localparam int POS_W     = PULSE_W + FRACTION_BITS;
    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    // Configuration limits and reset values
    localparam int SPEED_MIN     = 50;
    localparam int SPEED_MAX     = 4000;
    localparam int SPEED_RESET   = 1000;
    localparam int FLOOR_RESET   = 500;
    localparam int CEILING_RESET = 2500;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SLEW_SPEED    = 2'd0,
        REG_PULSE_FLOOR   = 2'd1,
        REG_PULSE_CEILING = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_SET_TARGET = 2'd0,
        OP_SET_ENABLE = 2'd1,
        OP_TICK       = 2'd2,
        OP_QUERY      = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DRIVE  = 2'd0,
        KIND_OFF    = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_ACK    = 2'd3
    } kind_t;

    // Settings handed from the register block to the datapath
    typedef struct packed {
        logic [PULSE_W-1:0] slew_speed;
        logic [PULSE_W-1:0] pulse_floor;
        logic [PULSE_W-1:0] pulse_ceiling;
        logic [POS_W-1:0]   step;
    } cfg_t;

endpackage

/* rtl/core/msl_cfg.sv */
// Configuration registers behind the APB-style port, plus the per-tick step
// (slew_speed << FRACTION_BITS) / TICK_RATE_HZ. Depends on msl_pkg.
module msl_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msl_pkg::ADDR_W-1:0]  paddr,
    input  logic [msl_pkg::DATA_W-1:0]  pwdata,
    output logic [msl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output msl_pkg::cfg_t               cfg
);
    import msl_pkg::*;

    localparam longint unsigned RECIP_L = (64'd1 << POS_W) / TICK_RATE_HZ;
    localparam logic [POS_W:0] RECIP    = (POS_W + 1)'(RECIP_L);
    localparam longint unsigned STEP_L  =
        (longint'(SPEED_RESET) << FRACTION_BITS) / TICK_RATE_HZ;
    localparam logic [POS_W-1:0] STEP_RESET = POS_W'(STEP_L);
    localparam logic [POS_W-1:0] TICK_C     = POS_W'(TICK_RATE_HZ);

    logic [PULSE_W-1:0] speed_reg, speed_next;
    logic [PULSE_W-1:0] floor_reg, ceiling_reg;
    logic [POS_W-1:0]   est_reg, est_next;
    logic [POS_W-1:0]   step_reg, step_next;
    logic               wr_en;
    reg_idx_t           wr_idx;
    logic [PULSE_W-1:0] wr_val;
    logic [POS_W-1:0]   x_new, x_cur, rem;
    logic [2*POS_W:0]   prod;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_val = pwdata[PULSE_W-1:0];

    // Saturate the speed and take a reciprocal estimate, low by at most one
    always_comb begin
        if (wr_val < PULSE_W'(SPEED_MIN)) begin
            speed_next = PULSE_W'(SPEED_MIN);
        end else if (wr_val > PULSE_W'(SPEED_MAX)) begin
            speed_next = PULSE_W'(SPEED_MAX);
        end else begin
            speed_next = wr_val;
        end
        x_new    = POS_W'(speed_next) << FRACTION_BITS;
        prod     = (2 * POS_W + 1)'(x_new) * (2 * POS_W + 1)'(RECIP);
        est_next = prod[2*POS_W-1:POS_W];
    end

    // Correct the estimate against the stored speed
    always_comb begin
        x_cur = POS_W'(speed_reg) << FRACTION_BITS;
        rem   = x_cur - POS_W'(est_reg * TICK_C);
        if (rem >= TICK_C) begin
            step_next = est_reg + POS_W'(1);
        end else begin
            step_next = est_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg   <= PULSE_W'(SPEED_RESET);
            floor_reg   <= PULSE_W'(FLOOR_RESET);
            ceiling_reg <= PULSE_W'(CEILING_RESET);
            est_reg     <= STEP_RESET;
            step_reg    <= STEP_RESET;
        end else begin
            step_reg <= step_next;
            if (wr_en) begin
                case (wr_idx)
                    REG_SLEW_SPEED: begin
                        speed_reg <= speed_next;
                        est_reg   <= est_next;
                    end
                    REG_PULSE_FLOOR:   floor_reg   <= wr_val;
                    REG_PULSE_CEILING: ceiling_reg <= wr_val;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (wr_idx)
            REG_SLEW_SPEED:    prdata = DATA_W'(speed_reg);
            REG_PULSE_FLOOR:   prdata = DATA_W'(floor_reg);
            REG_PULSE_CEILING: prdata = DATA_W'(ceiling_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.slew_speed    = speed_reg;
    assign cfg.pulse_floor   = floor_reg;
    assign cfg.pulse_ceiling = ceiling_reg;
    assign cfg.step          = step_reg;

endmodule

/* rtl/core/multichannel_servo_slew_limiter.sv */
// Top level of the multichannel servo slew limiter: sequencer, position and
// target memories, result register. Depends on msl_pkg and msl_cfg.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_op, s_channel, s_pulse_request,
//                                            s_enable_value
//  m_        out        m_valid / m_ready    m_kind, m_out_channel, m_pulse_us,
//                                            m_last
//  APB       in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A tick walks the channels one per cycle, while the result channel is free,
// through the single read port of the position memory, and stops after the
// last attached channel; it returns at once when outputs are off or no channel
// is attached.
// Reset clears control state and the attached bits and reloads the configuration
// registers; the memories need no clearing pass, since an entry is only used once attached.
// A stalled result holds the sequencer; a waiting result does not block the
// next transaction from being accepted.
module multichannel_servo_slew_limiter (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [msl_pkg::OP_W-1:0]           s_op,
    input  logic [msl_pkg::CH_W-1:0]           s_channel,
    input  logic signed [msl_pkg::REQ_W-1:0]   s_pulse_request,
    input  logic                               s_enable_value,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [msl_pkg::KIND_W-1:0]         m_kind,
    output logic [msl_pkg::CH_W-1:0]           m_out_channel,
    output logic signed [msl_pkg::OUT_W-1:0]   m_pulse_us,
    output logic                               m_last,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msl_pkg::ADDR_W-1:0]         paddr,
    input  logic [msl_pkg::DATA_W-1:0]         pwdata,
    output logic [msl_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import msl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_OFF,
        ST_SCAN
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CHANNELS - 1);
    localparam logic [CH_W:0]    CH_LIMIT  = (CH_W + 1)'(CHANNELS);

    cfg_t cfg;

    msl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Control and result registers
    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic signed [REQ_W-1:0] req_reg, req_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CHANNELS-1:0]     attached_reg, attached_next;
    logic                    outputs_on_reg, outputs_on_next;
    logic                    m_valid_reg, m_valid_next;
    kind_t                   m_kind_reg, m_kind_next;
    logic [CH_W-1:0]         m_ch_reg, m_ch_next;
    logic signed [OUT_W-1:0] m_pulse_reg, m_pulse_next;
    logic                    m_last_reg, m_last_next;

    // State memories: one write and one read port each, registered read data
    logic [POS_W-1:0]   pos_mem [CHANNELS];
    logic [PULSE_W-1:0] tgt_mem [CHANNELS];
    logic [POS_W-1:0]   pos_q;
    logic [PULSE_W-1:0] tgt_q;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               pos_we, tgt_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [POS_W-1:0]   pos_wdata;

    // Datapath
    logic               accept, out_free;
    logic [PULSE_W-1:0] clamped;
    logic               ch_in_range;
    logic [POS_W-1:0]   tf, up_gap, dn_gap, pos_new;
    logic               cur_att, higher_att, emit_now, advance, scan_done;
    logic               is_tick;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Clamp: floor first, then ceiling
    always_comb begin
        if (req_reg < $signed({{(REQ_W - PULSE_W){1'b0}}, cfg.pulse_floor})) begin
            clamped = cfg.pulse_floor;
        end else if (req_reg > $signed({{(REQ_W - PULSE_W){1'b0}}, cfg.pulse_ceiling})) begin
            clamped = cfg.pulse_ceiling;
        end else begin
            clamped = req_reg[PULSE_W-1:0];
        end
    end

    assign ch_in_range = {1'b0, ch_reg} < CH_LIMIT;

    // Move one step toward the target, never past it
    always_comb begin
        tf     = POS_W'(tgt_q) << FRACTION_BITS;
        up_gap = tf - pos_q;
        dn_gap = pos_q - tf;
        if (tf > pos_q) begin
            pos_new = (up_gap > cfg.step) ? pos_q + cfg.step : tf;
        end else if (pos_q > tf) begin
            pos_new = (dn_gap > cfg.step) ? pos_q - cfg.step : tf;
        end else begin
            pos_new = pos_q;
        end
    end

    // Any attached channel above the current one
    always_comb begin
        higher_att = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (i > int'(idx_reg) && attached_reg[i]) begin
                higher_att = 1'b1;
            end
        end
    end

    assign is_tick   = (op_reg == OP_TICK);
    assign cur_att   = attached_reg[idx_reg];
    assign emit_now  = is_tick ? cur_att : 1'b1;
    assign advance   = (state_reg == ST_SCAN) && (!emit_now || out_free);
    assign scan_done = is_tick ? ((cur_att && !higher_att) || idx_reg == LAST_IDX)
                               : (idx_reg == LAST_IDX);

    // Start reads at channel zero on acceptance, then walk with the index
    assign rd_en   = (accept && (s_op == OP_TICK || s_op == OP_QUERY))
                  || (advance && !scan_done);
    assign rd_addr = accept ? '0 : idx_reg + IDX_W'(1);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        ch_next         = ch_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        attached_next   = attached_reg;
        outputs_on_next = outputs_on_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_ch_next       = m_ch_reg;
        m_pulse_next    = m_pulse_reg;
        m_last_next     = m_last_reg;
        pos_we          = 1'b0;
        tgt_we          = 1'b0;
        wr_addr         = idx_reg;
        pos_wdata       = pos_new;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next  = op_t'(s_op);
                    ch_next  = s_channel;
                    req_next = s_pulse_request;
                    idx_next = '0;
                    case (op_t'(s_op))
                        OP_SET_TARGET: state_next = ST_ACK;
                        OP_SET_ENABLE: begin
                            outputs_on_next = s_enable_value;
                            if (s_enable_value) begin
                                state_next = ST_ACK;
                            end else begin
                                // Go limp: detach everything, report each channel off
                                attached_next = '0;
                                state_next    = ST_OFF;
                            end
                        end
                        OP_TICK: begin
                            if (outputs_on_reg && (|attached_reg)) begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: state_next = ST_SCAN;
                    endcase
                end
            end

            ST_ACK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_ACK;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                    if (op_reg == OP_SET_TARGET) begin
                        m_ch_next    = ch_reg;
                        m_pulse_next = OUT_W'(clamped);
                        wr_addr      = ch_reg[IDX_W-1:0];
                        pos_wdata    = POS_W'(clamped) << FRACTION_BITS;
                        if (ch_in_range) begin
                            tgt_we = 1'b1;
                            // First target snaps the position and attaches
                            if (!attached_reg[ch_reg[IDX_W-1:0]]) begin
                                pos_we = 1'b1;
                                attached_next[ch_reg[IDX_W-1:0]] = 1'b1;
                            end
                        end
                    end else begin
                        m_ch_next    = '0;
                        m_pulse_next = OUT_W'(1);
                    end
                end
            end

            ST_OFF: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_OFF;
                    m_ch_next    = CH_W'(idx_reg);
                    m_pulse_next = '0;
                    m_last_next  = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_SCAN: begin
                if (advance) begin
                    if (emit_now) begin
                        m_valid_next = 1'b1;
                        m_ch_next    = CH_W'(idx_reg);
                        m_last_next  = scan_done;
                        if (is_tick) begin
                            m_kind_next  = KIND_DRIVE;
                            m_pulse_next = OUT_W'(pos_new >> FRACTION_BITS);
                            pos_we       = 1'b1;
                        end else begin
                            m_kind_next  = KIND_REPORT;
                            m_pulse_next = cur_att ? OUT_W'(pos_q >> FRACTION_BITS) : '1;
                        end
                    end
                    if (scan_done) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            attached_reg   <= '0;
            outputs_on_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            attached_reg   <= attached_next;
            outputs_on_reg <= outputs_on_next;
            m_valid_reg    <= m_valid_next;
        end
        op_reg      <= op_next;
        ch_reg      <= ch_next;
        req_reg     <= req_next;
        m_kind_reg  <= m_kind_next;
        m_ch_reg    <= m_ch_next;
        m_pulse_reg <= m_pulse_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[wr_addr] <= pos_wdata;
        end
        if (tgt_we) begin
            tgt_mem[wr_addr] <= clamped;
        end
        if (rd_en) begin
            pos_q <= pos_mem[rd_addr];
            tgt_q <= tgt_mem[rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_out_channel = m_ch_reg;
    assign m_pulse_us    = m_pulse_reg;
    assign m_last        = m_last_reg;

    // A disable detaches every channel and turns outputs off on the next edge
    a_disable_detaches: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_SET_ENABLE && !s_enable_value)
        |=> (attached_reg == '0 && !outputs_on_reg))
        else $error("disable did not detach all channels");

    // Memories are written only while a transaction is being worked on
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!pos_we && !tgt_we))
        else $error("state memory written while idle");

    // A tick only moves channels that are attached
    a_tick_attached: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_we && state_reg == ST_SCAN) |-> attached_reg[idx_reg])
        else $error("tick wrote an unattached channel");

endmodule

/* dv/multichannel_servo_slew_limiter_tb.sv */
// Self-checking testbench for the multichannel servo slew limiter: directed and
// random transactions, APB register settings and output back-pressure, scored
// against a built-in predictor. Depends on msl_pkg and the RTL.
`timescale 1ns / 100ps

module multichannel_servo_slew_limiter_tb;
    import msl_pkg::*;

    // Cycles with no accepted transaction on any port before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = CHANNELS + 4;
    localparam int IDLE_PERCENT  = 34;

    typedef struct {
        kind_t              kind;
        logic [CH_W-1:0]    chan;
        logic [OUT_W-1:0]   pulse;
        logic               last;
    } servo_result_t;

    // Clock, reset and DUT ports; every input starts at a known value.
    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    op_t                        s_op            = OP_QUERY;
    logic [CH_W-1:0]            s_channel       = '0;
    logic signed [REQ_W-1:0]    s_pulse_request = '0;
    logic                       s_enable_value  = 1'b0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic [KIND_W-1:0]          m_kind;
    logic [CH_W-1:0]            m_out_channel;
    logic signed [OUT_W-1:0]    m_pulse_us;
    logic                       m_last;
    logic                       psel            = 1'b0;
    logic                       penable         = 1'b0;
    logic                       pwrite          = 1'b0;
    logic [ADDR_W-1:0]          paddr           = '0;
    logic [DATA_W-1:0]          pwdata          = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    // Predictor state: a private copy of the servo channels and the settings.
    logic [POS_W-1:0]           servo_pos   [CHANNELS];
    logic [PULSE_W-1:0]         servo_tgt   [CHANNELS];
    logic                       servo_held  [CHANNELS];
    logic                       outputs_on;
    logic [PULSE_W-1:0]         cfg_speed;
    logic [PULSE_W-1:0]         cfg_floor;
    logic [PULSE_W-1:0]         cfg_ceiling;

    servo_result_t              pending_results[$];
    int                         error_count    = 0;
    int                         quiet_cycles   = 0;
    bit                         steady_traffic = 1'b0;
    bit                         stall_request  = 1'b0;
    int                         stall_left     = 0;

    always #6 aclk = ~aclk;

    multichannel_servo_slew_limiter u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_channel       (s_channel),
        .s_pulse_request (s_pulse_request),
        .s_enable_value  (s_enable_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_out_channel   (m_out_channel),
        .m_pulse_us      (m_pulse_us),
        .m_last          (m_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic queue_result(kind_t kind, logic [CH_W-1:0] chan,
                                logic [OUT_W-1:0] pulse, logic last);
        servo_result_t r;
        r.kind  = kind;
        r.chan  = chan;
        r.pulse = pulse;
        r.last  = last;
        pending_results.push_back(r);
    endtask

    // Work out the results of one accepted transaction and advance the channel state.
    task automatic predict_servo(op_t op, logic [CH_W-1:0] chan,
                                 logic signed [REQ_W-1:0] req, logic en);
        int                 request;
        logic [PULSE_W-1:0] clamped;
        int                 step_size;
        int                 goal;
        int                 pos;
        int                 final_ch;
        request = req;
        case (op)
            OP_SET_TARGET: begin
                // Floor wins over ceiling when the window is inverted.
                if (request < int'(cfg_floor)) begin
                    clamped = cfg_floor;
                end else if (request > int'(cfg_ceiling)) begin
                    clamped = cfg_ceiling;
                end else begin
                    clamped = request[PULSE_W-1:0];
                end
                // Out-of-range channels change nothing but are still acknowledged.
                if (chan < CHANNELS) begin
                    servo_tgt[chan] = clamped;
                    if (!servo_held[chan]) begin
                        servo_pos[chan]  = POS_W'(clamped) << FRACTION_BITS;
                        servo_held[chan] = 1'b1;
                    end
                end
                queue_result(KIND_ACK, chan, OUT_W'(clamped), 1'b1);
            end
            OP_SET_ENABLE: begin
                outputs_on = en;
                if (en) begin
                    queue_result(KIND_ACK, '0, OUT_W'(1), 1'b1);
                end else begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        servo_held[c] = 1'b0;
                        queue_result(KIND_OFF, c[CH_W-1:0], '0, c == CHANNELS - 1);
                    end
                end
            end
            OP_TICK: begin
                if (outputs_on) begin
                    step_size = (int'(cfg_speed) << FRACTION_BITS) / TICK_RATE_HZ;
                    final_ch  = -1;
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (servo_held[c]) final_ch = c;
                    end
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (servo_held[c]) begin
                            goal = int'(servo_tgt[c]) << FRACTION_BITS;
                            pos  = int'(servo_pos[c]);
                            if (goal > pos) begin
                                pos = (goal - pos > step_size) ? pos + step_size : goal;
                            end else if (pos > goal) begin
                                pos = (pos - goal > step_size) ? pos - step_size : goal;
                            end
                            servo_pos[c] = pos[POS_W-1:0];
                            queue_result(KIND_DRIVE, c[CH_W-1:0],
                                         OUT_W'(servo_pos[c] >> FRACTION_BITS), c == final_ch);
                        end
                    end
                end
            end
            default: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    queue_result(KIND_REPORT, c[CH_W-1:0],
                                 servo_held[c] ? OUT_W'(servo_pos[c] >> FRACTION_BITS)
                                               : {OUT_W{1'b1}},
                                 c == CHANNELS - 1);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one transaction, hold it until accepted, then predict its results.
    task automatic drive_command(op_t op, int chan, int req, logic en);
        if (!steady_traffic) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_channel       <= chan[CH_W-1:0];
        s_pulse_request <= req[REQ_W-1:0];
        s_enable_value  <= en;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_servo(op, chan[CH_W-1:0], req[REQ_W-1:0], en);
    endtask

    // Drop valid, wait for every expected result, then let a silent tick finish.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write while the block is idle: setup cycle, then access cycle.
    task automatic write_setting(reg_idx_t idx, logic [DATA_W-1:0] data);
        logic [PULSE_W-1:0] v;
        settle_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Only the low 12 bits count; speed saturates to its legal range.
        v = data[PULSE_W-1:0];
        case (idx)
            REG_SLEW_SPEED: begin
                if (v < SPEED_MIN) v = PULSE_W'(SPEED_MIN);
                if (v > SPEED_MAX) v = PULSE_W'(SPEED_MAX);
                cfg_speed = v;
            end
            REG_PULSE_FLOOR:   cfg_floor   = v;
            REG_PULSE_CEILING: cfg_ceiling = v;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing attached after reset: reports are all -1 and a tick is silent.
    task automatic check_reset_state();
        drive_command(OP_QUERY, 0, 0, 1'b0);
        drive_command(OP_TICK, 0, 0, 1'b0);
        drive_command(OP_SET_ENABLE, 0, 0, 1'b1);
    endtask

    // Window clamping at both edges, full-range requests, out-of-range channels.
    task automatic check_target_clamping();
        drive_command(OP_SET_TARGET, 0, -65536, 1'b0);
        drive_command(OP_SET_TARGET, 1, 65535, 1'b1);
        drive_command(OP_SET_TARGET, 2, 499, 1'b0);
        drive_command(OP_SET_TARGET, 3, 500, 1'b0);
        drive_command(OP_SET_TARGET, 4, 2501, 1'b0);
        drive_command(OP_SET_TARGET, 5, 2500, 1'b0);
        drive_command(OP_SET_TARGET, 15, 1000, 1'b0);
        drive_command(OP_SET_TARGET, CHANNELS, 0, 1'b0);
        // Already attached: only the target moves.
        drive_command(OP_SET_TARGET, 0, 2000, 1'b0);
    endtask

    // Step attached channels toward their targets.
    task automatic check_slewing();
        repeat (3) drive_command(OP_TICK, 0, 0, 1'b0);
        drive_command(OP_QUERY, 0, 0, 1'b0);
    endtask

    // Disable detaches all; ticks go silent; a new target re-attaches at once.
    task automatic check_disable();
        drive_command(OP_SET_ENABLE, 0, 0, 1'b0);
        drive_command(OP_TICK, 0, 0, 1'b0);
        drive_command(OP_SET_TARGET, 2, 1500, 1'b0);
        drive_command(OP_QUERY, 0, 0, 1'b0);
        drive_command(OP_SET_ENABLE, 0, 0, 1'b1);
        drive_command(OP_TICK, 0, 0, 1'b0);
    endtask

    // Register extremes: saturating speed, full and inverted window, unused index.
    task automatic check_register_extremes();
        write_setting(REG_SLEW_SPEED, 32'd0);
        write_setting(REG_PULSE_FLOOR, 32'd0);
        write_setting(REG_PULSE_CEILING, 32'd4095);
        drive_command(OP_SET_TARGET, 1, 4095, 1'b0);
        drive_command(OP_SET_TARGET, 3, 0, 1'b0);
        repeat (2) drive_command(OP_TICK, 0, 0, 1'b0);
        write_setting(REG_SLEW_SPEED, 32'h0000_0FFF);
        repeat (2) drive_command(OP_TICK, 0, 0, 1'b0);
        // Upper bits are dropped, leaving a value below the speed floor.
        write_setting(REG_SLEW_SPEED, 32'hFFFF_F020);
        drive_command(OP_TICK, 0, 0, 1'b0);
        write_setting(REG_PULSE_FLOOR, 32'd3000);
        write_setting(REG_PULSE_CEILING, 32'd1000);
        drive_command(OP_SET_TARGET, 4, 2000, 1'b0);
        drive_command(OP_SET_TARGET, 5, 100, 1'b0);
        drive_command(OP_TICK, 0, 0, 1'b0);
        write_setting(REG_UNUSED, 32'hFFFF_FFFF);
        write_setting(REG_SLEW_SPEED, 32'd4000);
        write_setting(REG_PULSE_FLOOR, 32'd4095);
        write_setting(REG_PULSE_CEILING, 32'd0);
        drive_command(OP_SET_TARGET, 0, 0, 1'b0);
        drive_command(OP_QUERY, 0, 0, 1'b0);
    endtask

    // Mostly well-formed traffic: targets on live channels and ticks, with
    // queries, enable toggles and fully random transactions mixed in.
    task automatic random_command();
        int   pick;
        logic en;
        pick = $urandom_range(0, 99);
        en   = 1'($urandom_range(0, 1));
        if (pick < 40) begin
            drive_command(OP_SET_TARGET, $urandom_range(0, CHANNELS - 1),
                          int'($urandom_range(0, 3400)) - 200, en);
        end else if (pick < 70) begin
            drive_command(OP_TICK, $urandom_range(0, 15), $urandom(), en);
        end else if (pick < 80) begin
            drive_command(OP_QUERY, $urandom_range(0, 15), $urandom(), en);
        end else if (pick < 88) begin
            drive_command(OP_SET_TARGET, $urandom_range(0, 15), $urandom(), en);
        end else if (pick < 94) begin
            drive_command(OP_SET_ENABLE, $urandom_range(0, 15), $urandom(), 1'b1);
        end else if (pick < 97) begin
            drive_command(OP_SET_ENABLE, $urandom_range(0, 15), $urandom(), 1'b0);
        end else begin
            drive_command(op_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom(), en);
        end
    endtask

    // Five phases under different settings; one phase runs without idling.
    task automatic check_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            write_setting(REG_SLEW_SPEED, (phase == 1) ? 32'd50 : $urandom_range(0, 4095));
            write_setting(REG_PULSE_FLOOR, $urandom_range(0, 1200));
            write_setting(REG_PULSE_CEILING, $urandom_range(1800, 4095));
            steady_traffic = (phase == 3);
            repeat (42) random_command();
        end
        steady_traffic = 1'b0;
    endtask

    // Hold the receiver off for a long stretch while transactions keep coming,
    // so the result path fills and the input stalls.
    task automatic check_output_backpressure();
        stall_request = 1'b1;
        for (int i = 0; i < 24; i++) begin
            drive_command((i % 3 == 0) ? OP_TICK : OP_QUERY, 0, 0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Random ready with an on-demand hold-off counted here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_request) begin
            stall_request = 1'b0;
            stall_left    = HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready   <= 1'b0;
        end else if (steady_traffic) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        servo_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: kind %0d ch %0d pulse %0d last %0d",
                             m_kind, m_out_channel, m_pulse_us, m_last);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_kind !== want.kind || m_out_channel !== want.chan ||
                    m_pulse_us !== want.pulse || m_last !== want.last) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $write("mismatch: expected kind %0d ch %0d pulse %0d last %0d, ",
                               want.kind, want.chan, $signed(want.pulse), want.last);
                        $display("got kind %0d ch %0d pulse %0d last %0d",
                                 m_kind, m_out_channel, m_pulse_us, m_last);
                    end
                end
            end
        end
    end

    // Fail the run when no transaction moves on any port for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // Mirror the reset state of the block.
        for (int c = 0; c < CHANNELS; c++) begin
            servo_pos[c]  = '0;
            servo_tgt[c]  = '0;
            servo_held[c] = 1'b0;
        end
        outputs_on  = 1'b1;
        cfg_speed   = PULSE_W'(SPEED_RESET);
        cfg_floor   = PULSE_W'(FLOOR_RESET);
        cfg_ceiling = PULSE_W'(CEILING_RESET);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_reset_state();
        check_target_clamping();
        check_slewing();
        check_disable();
        check_register_extremes();
        check_random_traffic();
        check_output_backpressure();

        settle_block();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
